// ===== src/mcmf_pkg.sv =====
// ----------------------------------------------------------------------------
// mcmf_pkg
// Types and constants shared by the MIDI channel message filter modules.
// ----------------------------------------------------------------------------
package mcmf_pkg;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 40;
	localparam int unsigned TDATA_W     = 24;
	localparam int unsigned NUM_TYPES   = 6;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_CHAN_NOTE_WIN = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_VEL_WIN       = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_VEL_GAIN      = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_TRANSPOSE     = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_TYPE_BLOCK    = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_CHAN_OVERRIDE = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_CC_MATCH      = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_CC_REMAP      = 3'd7;

	// status byte high nibble
	localparam logic [3:0] KIND_NOTE_OFF  = 4'h8;
	localparam logic [3:0] KIND_NOTE_ON   = 4'h9;
	localparam logic [3:0] KIND_POLY      = 4'hA;
	localparam logic [3:0] KIND_CC        = 4'hB;
	localparam logic [3:0] KIND_PROG      = 4'hC;
	localparam logic [3:0] KIND_PRESSURE  = 4'hD;
	localparam logic [3:0] KIND_BEND      = 4'hE;

	localparam logic [4:0] CHAN_KEEP = 5'd31;

	typedef enum logic [2:0] {
		TYPE_NOTE     = 3'd0,
		TYPE_POLY     = 3'd1,
		TYPE_CC       = 3'd2,
		TYPE_PROG     = 3'd3,
		TYPE_PRESSURE = 3'd4,
		TYPE_BEND     = 3'd5
	} msg_type_t;

	typedef struct packed {
		logic [4:0]        chan_lo;
		logic [4:0]        chan_hi;
		logic [6:0]        note_lo;
		logic [6:0]        note_hi;
		logic [6:0]        vel_lo;
		logic [6:0]        vel_hi;
		logic [11:0]       vel_gain;
		logic signed [7:0] transpose;
		logic [5:0]        type_block;
		logic [29:0]       chan_override;
		logic [34:0]       cc_match;
		logic [34:0]       cc_target;
		logic [4:0]        cc_enable;
	} cfg_t;

	typedef struct packed {
		logic [7:0] status;
		logic [6:0] data_first;
		logic [6:0] data_second;
		logic [1:0] byte_count;
	} msg_t;

	typedef struct packed {
		msg_t      msg;
		msg_type_t kind;
		logic      remap;
	} job_t;

endpackage

// ===== src/mcmf_cfg.sv =====
// ----------------------------------------------------------------------------
// mcmf_cfg
// Configuration register file, written through the index/data channel.
// ----------------------------------------------------------------------------
module mcmf_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [mcmf_pkg::CFG_INDEX_W-1:0]  wr_index,
	input  logic [mcmf_pkg::CFG_DATA_W-1:0]   wr_data,
	output mcmf_pkg::cfg_t                    cfg
);
	import mcmf_pkg::*;

	logic [23:0] chan_note_win_q;
	logic [13:0] vel_win_q;
	logic [11:0] vel_gain_q;
	logic [7:0]  transpose_q;
	logic [5:0]  type_block_q;
	logic [29:0] chan_override_q;
	logic [34:0] cc_match_q;
	logic [39:0] cc_remap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_note_win_q <= 24'hFE0201;
			vel_win_q       <= 14'h3F80;
			vel_gain_q      <= 12'h100;
			transpose_q     <= 8'h00;
			type_block_q    <= 6'h00;
			chan_override_q <= 30'h3FFFFFFF;
			cc_match_q      <= 35'h0;
			cc_remap_q      <= 40'h0;
		end else if (wr_en) begin
			case (wr_index)
				REG_CHAN_NOTE_WIN: chan_note_win_q <= wr_data[23:0];
				REG_VEL_WIN:       vel_win_q       <= wr_data[13:0];
				REG_VEL_GAIN:      vel_gain_q      <= wr_data[11:0];
				REG_TRANSPOSE:     transpose_q     <= wr_data[7:0];
				REG_TYPE_BLOCK:    type_block_q    <= wr_data[5:0];
				REG_CHAN_OVERRIDE: chan_override_q <= wr_data[29:0];
				REG_CC_MATCH:      cc_match_q      <= wr_data[34:0];
				REG_CC_REMAP:      cc_remap_q      <= wr_data[39:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg.chan_lo       = chan_note_win_q[4:0];
	assign cfg.chan_hi       = chan_note_win_q[9:5];
	assign cfg.note_lo       = chan_note_win_q[16:10];
	assign cfg.note_hi       = chan_note_win_q[23:17];
	assign cfg.vel_lo        = vel_win_q[6:0];
	assign cfg.vel_hi        = vel_win_q[13:7];
	assign cfg.vel_gain      = vel_gain_q;
	assign cfg.transpose     = $signed(transpose_q);
	assign cfg.type_block    = type_block_q;
	assign cfg.chan_override = chan_override_q;
	assign cfg.cc_match      = cc_match_q;
	assign cfg.cc_target     = cc_remap_q[34:0];
	assign cfg.cc_enable     = cc_remap_q[39:35];

endmodule

// ===== src/mcmf_xform.sv =====
// ----------------------------------------------------------------------------
// mcmf_xform
// Single-pass message transform: filtering, channel override, transpose,
// velocity scaling and controller slot matching.
// ----------------------------------------------------------------------------
module mcmf_xform #(
	parameter int unsigned CC_SLOTS = 5
) (
	input  mcmf_pkg::cfg_t       cfg,
	input  mcmf_pkg::msg_t       msg,
	output logic                 keep,
	output mcmf_pkg::job_t       job,
	output logic [CC_SLOTS-1:0]  mask
);
	import mcmf_pkg::*;

	logic [3:0]           kind;
	logic [3:0]           chan;
	logic [4:0]           chan_num;
	logic                 voice;
	msg_type_t            mtype;
	logic [NUM_TYPES-1:0] type_oh;
	logic                 chan_ok;
	logic                 blocked;
	logic [4:0]           slot;
	logic [3:0]           out_chan;
	logic                 note_ok;
	logic signed [8:0]    note_sum;
	logic [6:0]           note_out;
	logic [18:0]          vel_prod;
	logic [10:0]          vel_scaled;
	logic [6:0]           vel_hi_clamp;
	logic [6:0]           vel_out;
	logic                 scale_vel;
	logic [CC_SLOTS-1:0]  cc_hit;
	logic [CC_SLOTS-1:0]  cc_take;

	always_comb begin
		kind  = msg.status[7:4];
		chan  = msg.status[3:0];
		voice = 1'b1;
		case (kind)
			KIND_NOTE_OFF, KIND_NOTE_ON: mtype = TYPE_NOTE;
			KIND_POLY:                   mtype = TYPE_POLY;
			KIND_CC:                     mtype = TYPE_CC;
			KIND_PROG:                   mtype = TYPE_PROG;
			KIND_PRESSURE:               mtype = TYPE_PRESSURE;
			KIND_BEND:                   mtype = TYPE_BEND;
			default: begin
				mtype = TYPE_NOTE;
				voice = 1'b0;
			end
		endcase
		type_oh = NUM_TYPES'(1) << mtype;

		chan_num = {1'b0, chan} + 5'd1;
		chan_ok  = (chan_num >= cfg.chan_lo) && (chan_num <= cfg.chan_hi);
		blocked  = |(type_oh & cfg.type_block);

		slot = '0;
		for (int t = 0; t < NUM_TYPES; t++) begin
			if (type_oh[t]) begin
				slot = slot | cfg.chan_override[5*t +: 5];
			end
		end
		out_chan = (slot == CHAN_KEEP) ? chan : slot[3:0];

		// transpose with clamp to 0..127
		note_ok  = (msg.data_first >= cfg.note_lo) && (msg.data_first <= cfg.note_hi);
		note_sum = $signed({cfg.transpose[7], cfg.transpose}) + $signed({2'b00, msg.data_first});
		if (note_sum < 9'sd0) begin
			note_out = 7'd0;
		end else if (note_sum > 9'sd127) begin
			note_out = 7'd127;
		end else begin
			note_out = note_sum[6:0];
		end

		// q4.8 velocity gain, high limit then low limit
		vel_prod     = 19'(cfg.vel_gain) * 19'(msg.data_second);
		vel_scaled   = vel_prod[18:8];
		vel_hi_clamp = (vel_scaled > {4'b0000, cfg.vel_hi}) ? cfg.vel_hi : vel_scaled[6:0];
		vel_out      = (vel_hi_clamp < cfg.vel_lo) ? cfg.vel_lo : vel_hi_clamp;
		scale_vel    = (kind == KIND_NOTE_ON) && (msg.data_second != 7'd0);

		for (int i = 0; i < CC_SLOTS; i++) begin
			cc_hit[i]  = (cfg.cc_match[7*i +: 7] == msg.data_first);
			cc_take[i] = cc_hit[i] & cfg.cc_enable[i];
		end

		keep                 = voice & chan_ok & ~blocked;
		job.msg.status       = {kind, out_chan};
		job.msg.data_first   = msg.data_first;
		job.msg.data_second  = msg.data_second;
		job.msg.byte_count   = msg.byte_count;
		job.kind             = mtype;
		job.remap            = 1'b0;
		mask                 = CC_SLOTS'(1);

		case (mtype)
			TYPE_NOTE, TYPE_POLY: begin
				keep               = keep & note_ok;
				job.msg.data_first = note_out;
				if (scale_vel) begin
					job.msg.data_second = vel_out;
				end
			end
			TYPE_CC: begin
				if (|cc_hit) begin
					job.remap = 1'b1;
					mask      = cc_take;
					keep      = keep & (|cc_take);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== src/mcmf_emit.sv =====
// ----------------------------------------------------------------------------
// mcmf_emit
// Result register; walks the controller slot mask, one result per transfer.
// ----------------------------------------------------------------------------
module mcmf_emit #(
	parameter int unsigned CC_SLOTS = 5
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            load,
	input  mcmf_pkg::job_t                  load_job,
	input  logic [CC_SLOTS-1:0]             load_mask,
	input  logic [34:0]                     cc_target,
	output logic                            free,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [mcmf_pkg::TDATA_W-1:0]    m_tdata,
	output logic [2:0]                      m_tuser,
	output logic                            m_tlast
);
	import mcmf_pkg::*;

	logic                valid_s2;
	job_t                job_s2;
	logic [CC_SLOTS-1:0] mask_s2;
	logic [CC_SLOTS-1:0] lowest;
	logic [CC_SLOTS-1:0] rest;
	logic [6:0]          target;
	logic [6:0]          data_first;
	logic                fire;

	assign lowest  = mask_s2 & (~mask_s2 + CC_SLOTS'(1));
	assign rest    = mask_s2 & ~lowest;
	assign m_tlast = (rest == '0);
	assign fire    = valid_s2 & m_tready;
	assign free    = ~valid_s2 | (m_tready & m_tlast);

	always_comb begin
		target = '0;
		for (int i = 0; i < CC_SLOTS; i++) begin
			if (lowest[i]) begin
				target = target | cc_target[7*i +: 7];
			end
		end
		data_first = job_s2.remap ? target : job_s2.msg.data_first;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			mask_s2  <= '0;
		end else if (load) begin
			valid_s2 <= 1'b1;
			mask_s2  <= load_mask;
		end else if (fire) begin
			valid_s2 <= ~m_tlast;
			mask_s2  <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			job_s2 <= load_job;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {job_s2.msg.byte_count, job_s2.msg.data_second, data_first,
		job_s2.msg.status};
	assign m_tuser  = job_s2.kind;

endmodule

// ===== src/midi_channel_message_filter_unit.sv =====
// path: input transfer -> input register -> result register -> first result
// throughput: one message per cycle unless the output stalls; a controller
// message matching k enabled slots holds the result register for k transfers
// reset: arst_n clears the valid flags of both pipeline stages and loads every
// configuration register with its default; no clearing pass
// ----------------------------------------------------------------------------
// midi_channel_message_filter_unit
// Stateless MIDI channel voice message filter, remapper and transposer.
// ----------------------------------------------------------------------------
module midi_channel_message_filter_unit #(
	parameter int unsigned CC_SLOTS = 5
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [mcmf_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [mcmf_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// status_byte, data_first, data_second, byte_count
	input  logic [mcmf_pkg::TDATA_W-1:0]       s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// out_status, out_data_first, out_data_second, out_byte_count
	output logic [mcmf_pkg::TDATA_W-1:0]       m_tdata,
	// type_port
	output logic [2:0]                         m_tuser,
	output logic                               m_tlast
);
	import mcmf_pkg::*;

	cfg_t                cfg;
	logic                valid_s1;
	msg_t                msg_s1;
	logic                keep;
	job_t                job;
	logic [CC_SLOTS-1:0] mask;
	logic                emit_free;
	logic                s1_done;
	logic                load;

	assign cfg_ready = 1'b1;

	mcmf_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign s1_done  = valid_s1 & (~keep | emit_free);
	assign load     = valid_s1 & keep & emit_free;
	assign s_tready = ~valid_s1 | s1_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid & s_tready) begin
			valid_s1 <= 1'b1;
		end else if (s1_done) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid & s_tready) begin
			msg_s1.status      <= s_tdata[7:0];
			msg_s1.data_first  <= s_tdata[14:8];
			msg_s1.data_second <= s_tdata[21:15];
			msg_s1.byte_count  <= s_tdata[23:22];
		end
	end

	mcmf_xform #(
		.CC_SLOTS (CC_SLOTS)
	) u_xform (
		.cfg  (cfg),
		.msg  (msg_s1),
		.keep (keep),
		.job  (job),
		.mask (mask)
	);

	mcmf_emit #(
		.CC_SLOTS (CC_SLOTS)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.load_job  (job),
		.load_mask (mask),
		.cc_target (cfg.cc_target),
		.free      (emit_free),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

`ifndef NO_ASSERTIONS
	// only controller remaps give more than one result
	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != TYPE_CC) |-> m_tlast)
		else $error("non-controller result without last");

	// a run that is not finished keeps presenting results
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("result run cut short");

	// every emitted status is a channel voice status
	a_voice_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7] && (m_tdata[7:4] != 4'hF))
		else $error("non-voice status emitted");

	// the result register is loaded only when it can take a new message
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> emit_free && keep)
		else $error("result register overwritten");
`endif

endmodule

// ===== sim/tb_midi_channel_message_filter_unit.sv =====
// ----------------------------------------------------------------------------
// tb_midi_channel_message_filter_unit
// Drives short MIDI messages into the filter under a series of register
// settings and checks every output transfer against a local prediction of
// the channel window, type blocking, channel override, note window,
// transpose, velocity scaling and controller remap rules. Both stream sides
// stall at random; one long output hold forces the input to back up.
// ----------------------------------------------------------------------------
module tb_midi_channel_message_filter_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import mcmf_pkg::*;

	localparam logic [3:0] KIND_SYSTEM = 4'hF;
	localparam int STUCK_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 8;

	typedef struct {
		logic [7:0] status;
		logic [6:0] data_first;
		logic [6:0] data_second;
		logic [1:0] byte_count;
		msg_type_t  port;
		logic       last;
	} midi_out_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [TDATA_W-1:0]     s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [TDATA_W-1:0]     m_tdata;
	logic [2:0]             m_tuser;
	logic                   m_tlast;

	// shadow copy of the register file
	logic [23:0]       note_win = 24'hFE0201;
	logic [13:0]       vel_win = 14'h3F80;
	logic [11:0]       vel_gain = 12'd256;
	logic signed [7:0] transp = 8'sd0;
	logic [5:0]        type_block = 6'd0;
	logic [29:0]       chan_ovr = '1;
	logic [34:0]       cc_match = '0;
	logic [39:0]       cc_remap = '0;

	midi_out_t filtered_msgs[$];
	int        mismatch_cnt = 0;
	int        stuck_cycles = 0;
	int        sink_wait = 0;
	int        sink_hold = 0;
	bit        sink_stall_on = 1'b1;
	bit        src_gap_on = 1'b1;

	midi_channel_message_filter_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always #1 clk = ~clk;

	function automatic void filter_message(input logic [7:0] st, input logic [6:0] n,
			input logic [6:0] v, input logic [1:0] cnt);
		midi_out_t   outs[$];
		midi_out_t   r;
		logic [3:0]  kind;
		logic [2:0]  tcode;
		msg_type_t   ty;
		logic [4:0]  slot;
		logic [3:0]  och;
		int          chan1;
		int          tn;
		int unsigned vv;
		bit          hit;
		kind = st[7:4];
		if (kind < KIND_NOTE_OFF || kind > KIND_BEND)
			return;
		tcode = 3'(kind - KIND_NOTE_ON);
		ty = (kind == KIND_NOTE_OFF) ? TYPE_NOTE : msg_type_t'(tcode);
		chan1 = int'(st[3:0]) + 1;
		if (chan1 < int'(note_win[4:0]) || chan1 > int'(note_win[9:5]))
			return;
		if (type_block[ty])
			return;
		slot = chan_ovr[5*ty +: 5];
		och = (slot == CHAN_KEEP) ? st[3:0] : slot[3:0];
		r.status = {kind, och};
		r.data_first = n;
		r.data_second = v;
		r.byte_count = cnt;
		r.port = ty;
		r.last = 1'b0;
		if (ty == TYPE_NOTE || ty == TYPE_POLY) begin
			if (n < note_win[16:10] || n > note_win[23:17])
				return;
			tn = int'(n) + int'(transp);
			if (tn > 127)
				tn = 127;
			if (tn < 0)
				tn = 0;
			r.data_first = tn[6:0];
			if (kind == KIND_NOTE_ON && v != 7'd0) begin
				vv = (int'(vel_gain) * int'(v)) >> 8;
				if (vv > vel_win[13:7])
					vv = 32'(vel_win[13:7]);
				if (vv < vel_win[6:0])
					vv = 32'(vel_win[6:0]);
				r.data_second = vv[6:0];
			end
			outs.push_back(r);
		end else if (ty == TYPE_CC) begin
			hit = 1'b0;
			for (int i = 0; i < 5; i++)
				if (cc_match[7*i +: 7] == n)
					hit = 1'b1;
			if (hit) begin
				for (int i = 0; i < 5; i++) begin
					if (cc_remap[35+i] && cc_match[7*i +: 7] == n) begin
						r.data_first = cc_remap[7*i +: 7];
						outs.push_back(r);
					end
				end
			end else begin
				outs.push_back(r);
			end
		end else begin
			outs.push_back(r);
		end
		if (outs.size() > 0)
			outs[outs.size()-1].last = 1'b1;
		foreach (outs[i])
			filtered_msgs.push_back(outs[i]);
	endfunction

	task automatic flag_mismatch(input string what);
		mismatch_cnt++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	task automatic send_msg(input logic [7:0] st, input logic [6:0] n, input logic [6:0] v,
			input logic [1:0] cnt);
		int gap;
		gap = src_gap_on ? $urandom_range(0, 19) : 0;
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {cnt, v, n, st};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		filter_message(st, n, v, cnt);
	endtask

	task automatic send_random_msg();
		logic [3:0] kind;
		logic [3:0] ch;
		logic [7:0] st;
		logic [6:0] n;
		logic [6:0] v;
		logic [1:0] cnt;
		int         lo;
		int         hi;
		kind = 4'($urandom_range(int'(KIND_NOTE_OFF), int'(KIND_BEND)));
		lo = (note_win[4:0] == 5'd0) ? 1 : int'(note_win[4:0]);
		hi = (note_win[9:5] > 5'd16) ? 16 : int'(note_win[9:5]);
		if (lo <= hi && $urandom_range(0, 4) != 0)
			ch = 4'($urandom_range(lo - 1, hi - 1));
		else
			ch = 4'($urandom_range(0, 15));
		n = 7'($urandom_range(0, 127));
		if ((kind == KIND_NOTE_OFF || kind == KIND_NOTE_ON || kind == KIND_POLY)
				&& note_win[16:10] <= note_win[23:17] && $urandom_range(0, 4) != 0)
			n = 7'($urandom_range(int'(note_win[16:10]), int'(note_win[23:17])));
		if (kind == KIND_CC && $urandom_range(0, 4) > 1)
			n = cc_match[7*$urandom_range(0, 4) +: 7];
		v = ($urandom_range(0, 7) == 0) ? 7'd0 : 7'($urandom_range(0, 127));
		cnt = ($urandom_range(0, 15) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
		st = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : {kind, ch};
		send_msg(st, n, v, cnt);
	endtask

	task automatic drain_block();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (filtered_msgs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_CHAN_NOTE_WIN: note_win = val[23:0];
			REG_VEL_WIN:       vel_win = val[13:0];
			REG_VEL_GAIN:      vel_gain = val[11:0];
			REG_TRANSPOSE:     transp = val[7:0];
			REG_TYPE_BLOCK:    type_block = val[5:0];
			REG_CHAN_OVERRIDE: chan_ovr = val[29:0];
			REG_CC_MATCH:      cc_match = val[34:0];
			REG_CC_REMAP:      cc_remap = val[39:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic apply_settings(input logic [23:0] win, input logic [13:0] vel,
			input logic [11:0] gain, input logic [7:0] tr, input logic [5:0] blk,
			input logic [29:0] ovr, input logic [34:0] ccm, input logic [39:0] cct);
		drain_block();
		write_reg(REG_CHAN_NOTE_WIN, CFG_DATA_W'(win));
		write_reg(REG_VEL_WIN, CFG_DATA_W'(vel));
		write_reg(REG_VEL_GAIN, CFG_DATA_W'(gain));
		write_reg(REG_TRANSPOSE, CFG_DATA_W'(tr));
		write_reg(REG_TYPE_BLOCK, CFG_DATA_W'(blk));
		write_reg(REG_CHAN_OVERRIDE, CFG_DATA_W'(ovr));
		write_reg(REG_CC_MATCH, CFG_DATA_W'(ccm));
		write_reg(REG_CC_REMAP, cct);
	endtask

	task automatic test_reset_defaults();
		send_msg({KIND_NOTE_OFF, 4'h0}, 7'd0, 7'd0, 2'd1);
		send_msg({KIND_NOTE_ON, 4'hF}, 7'd127, 7'd127, 2'd3);
		send_msg({KIND_NOTE_ON, 4'h1}, 7'd60, 7'd0, 2'd3);
		send_msg({KIND_POLY, 4'h5}, 7'd64, 7'd100, 2'd3);
		send_msg({KIND_CC, 4'h3}, 7'd7, 7'd127, 2'd3);
		send_msg({KIND_PROG, 4'h0}, 7'd5, 7'd0, 2'd2);
		send_msg({KIND_PRESSURE, 4'h7}, 7'd99, 7'd0, 2'd2);
		send_msg({KIND_BEND, 4'hF}, 7'd0, 7'd127, 2'd0);
		send_msg(8'h00, 7'd1, 7'd2, 2'd1);
		send_msg({KIND_SYSTEM, 4'h0}, 7'd127, 7'd127, 2'd3);
	endtask

	task automatic test_windows_and_override();
		apply_settings({7'd100, 7'd20, 5'd10, 5'd3}, {7'd30, 7'd40}, 12'hFFF, 8'sd127,
			6'd1 << TYPE_BEND, {5'd31, 5'd31, 5'd31, 5'd31, 5'd5, 5'd20},
			{7'd11, 7'd10, 7'd7, 7'd7, 7'd7},
			{5'b01101, 7'd50, 7'd40, 7'd30, 7'd20, 7'd10});
		send_msg({KIND_NOTE_ON, 4'h2}, 7'd50, 7'd100, 2'd3);
		send_msg({KIND_NOTE_ON, 4'h1}, 7'd50, 7'd100, 2'd3);
		send_msg({KIND_NOTE_ON, 4'hA}, 7'd50, 7'd100, 2'd3);
		send_msg({KIND_NOTE_ON, 4'h9}, 7'd19, 7'd100, 2'd3);
		send_msg({KIND_NOTE_OFF, 4'h5}, 7'd100, 7'd77, 2'd3);
		send_msg({KIND_POLY, 4'h3}, 7'd20, 7'd9, 2'd3);
		send_msg({KIND_BEND, 4'h3}, 7'd1, 7'd2, 2'd3);
		send_msg({KIND_CC, 4'h4}, 7'd7, 7'd55, 2'd3);
		send_msg({KIND_CC, 4'h4}, 7'd11, 7'd1, 2'd3);
		send_msg({KIND_CC, 4'h4}, 7'd10, 7'd2, 2'd3);
		send_msg({KIND_CC, 4'h4}, 7'd12, 7'd3, 2'd3);
		send_msg({KIND_PRESSURE, 4'h4}, 7'd33, 7'd0, 2'd2);
	endtask

	task automatic test_cc_fanout();
		drain_block();
		write_reg(REG_TRANSPOSE, CFG_DATA_W'(8'sh81));
		write_reg(REG_CC_MATCH, CFG_DATA_W'({5{7'd7}}));
		write_reg(REG_CC_REMAP, {5'b11111, 7'd5, 7'd4, 7'd3, 7'd2, 7'd1});
		send_msg({KIND_CC, 4'h3}, 7'd7, 7'd64, 2'd3);
		send_msg({KIND_NOTE_ON, 4'h3}, 7'd100, 7'd1, 2'd3);
		send_msg({KIND_POLY, 4'h3}, 7'd20, 7'd0, 2'd3);
	endtask

	task automatic test_backpressure();
		apply_settings(24'hFE0201, 14'h3F80, 12'd256, 8'sd0, 6'd0, '1, '0, '0);
		src_gap_on = 1'b0;
		@(posedge clk);
		sink_hold = 150;
		repeat (40)
			send_msg({KIND_NOTE_ON, 4'($urandom_range(0, 15))}, 7'($urandom_range(0, 127)),
				7'($urandom_range(0, 127)), 2'($urandom_range(1, 3)));
		drain_block();
		src_gap_on = 1'b1;
	endtask

	task automatic test_config_extremes();
		apply_settings('0, '0, '0, '0, '0, '0, '0, '0);
		repeat (8) send_random_msg();
		apply_settings('1, '1, '1, 8'sd127, '1, '1, '1, '1);
		repeat (8) send_random_msg();
		apply_settings({7'd127, 7'd0, 5'd31, 5'd0}, {7'd127, 7'd0}, 12'hFFF, 8'sh81, 6'd0,
			30'd0, {5{7'd127}}, {5'b11111, 35'd0});
		repeat (16) send_random_msg();
	endtask

	task automatic test_random_traffic();
		logic [23:0] win;
		logic [13:0] vel;
		logic [11:0] gain;
		logic [7:0]  tr;
		logic [5:0]  blk;
		logic [29:0] ovr;
		logic [34:0] ccm;
		logic [39:0] cct;
		for (int ph = 0; ph < 8; ph++) begin
			win = {7'($urandom_range(50, 127)), 7'($urandom_range(0, 60)),
				5'($urandom_range(8, 31)), 5'($urandom_range(0, 6))};
			if ($urandom_range(0, 5) == 0)
				win = 24'($urandom);
			vel = {7'($urandom_range(60, 127)), 7'($urandom_range(0, 40))};
			if ($urandom_range(0, 5) == 0)
				vel = 14'($urandom);
			gain = ($urandom_range(0, 1) == 0) ? 12'($urandom_range(64, 512))
				: 12'($urandom_range(0, 4095));
			tr = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 254) - 127)
				: 8'($urandom_range(0, 24) - 12);
			blk = 6'($urandom & $urandom);
			for (int t = 0; t < 6; t++)
				ovr[5*t +: 5] = ($urandom_range(0, 1) == 0) ? CHAN_KEEP
					: 5'($urandom_range(0, 30));
			for (int i = 0; i < 5; i++) begin
				case ($urandom_range(0, 2))
					0: ccm[7*i +: 7] = 7'd7;
					1: ccm[7*i +: 7] = 7'd64;
					default: ccm[7*i +: 7] = 7'($urandom_range(0, 127));
				endcase
				cct[7*i +: 7] = 7'($urandom_range(0, 127));
			end
			cct[39:35] = 5'($urandom_range(0, 31));
			apply_settings(win, vel, gain, tr, blk, ovr, ccm, cct);
			src_gap_on = (ph == 1) || (ph != 0 && $urandom_range(0, 3) != 0);
			sink_stall_on = (ph == 1) || (ph != 0 && $urandom_range(0, 3) != 0);
			repeat (17) send_random_msg();
		end
		sink_stall_on = 1'b1;
		src_gap_on = 1'b1;
	endtask

	// output side: per-transfer random stall plus an optional long hold
	initial begin
		forever begin
			@(negedge clk);
			if (sink_hold > 0) begin
				sink_hold--;
				m_tready <= 1'b0;
			end else if (sink_wait > 0) begin
				sink_wait--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_out
		midi_out_t want;
		if (arst_n && m_tvalid && m_tready) begin
			sink_wait = sink_stall_on ? $urandom_range(0, 19) : 0;
			if (filtered_msgs.size() == 0) begin
				flag_mismatch($sformatf("unexpected result tdata=%h tuser=%0d tlast=%b",
					m_tdata, m_tuser, m_tlast));
			end else begin
				want = filtered_msgs.pop_front();
				if (m_tdata[7:0] !== want.status)
					flag_mismatch($sformatf("status %h, want %h", m_tdata[7:0], want.status));
				if (m_tdata[14:8] !== want.data_first)
					flag_mismatch($sformatf("data_first %0d, want %0d", m_tdata[14:8],
						want.data_first));
				if (m_tdata[21:15] !== want.data_second)
					flag_mismatch($sformatf("data_second %0d, want %0d", m_tdata[21:15],
						want.data_second));
				if (m_tdata[23:22] !== want.byte_count)
					flag_mismatch($sformatf("byte_count %0d, want %0d", m_tdata[23:22],
						want.byte_count));
				if (m_tuser !== want.port)
					flag_mismatch($sformatf("type %0d, want %0d", m_tuser, want.port));
				if (m_tlast !== want.last)
					flag_mismatch($sformatf("tlast %b, want %b", m_tlast, want.last));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (cfg_valid && cfg_ready)) begin
			stuck_cycles = 0;
		end else begin
			stuck_cycles++;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", STUCK_LIMIT);
				$display("** midi_channel_message_filter_unit: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_windows_and_override();
		test_cc_fanout();
		test_backpressure();
		test_config_extremes();
		test_random_traffic();
		drain_block();
		if (filtered_msgs.size() != 0)
			flag_mismatch($sformatf("%0d results never arrived", filtered_msgs.size()));
		if (mismatch_cnt == 0)
			$display("** midi_channel_message_filter_unit: PASSED **");
		else
			$display("** midi_channel_message_filter_unit: FAILED **");
		$finish;
	end

endmodule

// ===== midi_channel_message_filter_unit.f =====
src/mcmf_pkg.sv
src/mcmf_cfg.sv
src/mcmf_xform.sv
src/mcmf_emit.sv
src/midi_channel_message_filter_unit.sv
sim/tb_midi_channel_message_filter_unit.sv
